// ===== rtl/taint_propagation_engine_defines.svh =====
// Assertion macros used by the taint propagation engine checker.
`ifndef TAINT_PROPAGATION_ENGINE_DEFINES_SVH
`define TAINT_PROPAGATION_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TPE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("taint engine check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("taint engine check failed");

`endif

// ===== rtl/tpe_pkg.sv =====
// Shared types, operation codes and default sizes of the taint propagation engine.
`timescale 1ns / 1ps
`default_nettype none

package tpe_pkg;

    localparam int NUM_REGS_DEF   = 64;
    localparam int ADDR_BITS_DEF  = 16;
    localparam int MAX_ACCESS_DEF = 16;

    localparam int ACTION_W = 4;
    localparam int REG_ID_W = 8;
    localparam int ADDR_W   = 16;
    localparam int SIZE_W   = 5;
    localparam int LANE_W   = 8;

    localparam logic [ACTION_W-1:0] ACT_QREG       = 4'd0;
    localparam logic [ACTION_W-1:0] ACT_QMEM       = 4'd1;
    localparam logic [ACTION_W-1:0] ACT_SETREG     = 4'd2;
    localparam logic [ACTION_W-1:0] ACT_SETMEM     = 4'd3;
    localparam logic [ACTION_W-1:0] ACT_ASSIGN_RR  = 4'd4;
    localparam logic [ACTION_W-1:0] ACT_ASSIGN_RI  = 4'd5;
    localparam logic [ACTION_W-1:0] ACT_ASSIGN_RM  = 4'd6;
    localparam logic [ACTION_W-1:0] ACT_ASSIGN_MM  = 4'd7;
    localparam logic [ACTION_W-1:0] ACT_ASSIGN_MI  = 4'd8;
    localparam logic [ACTION_W-1:0] ACT_ASSIGN_MR  = 4'd9;
    localparam logic [ACTION_W-1:0] ACT_EXPR_RR    = 4'd10;
    localparam logic [ACTION_W-1:0] ACT_EXPR_RM    = 4'd11;
    localparam logic [ACTION_W-1:0] ACT_ALU_RR     = 4'd12;
    localparam logic [ACTION_W-1:0] ACT_ALU_RM     = 4'd13;
    localparam logic [ACTION_W-1:0] ACT_ALU_MM     = 4'd14;
    localparam logic [ACTION_W-1:0] ACT_ALU_MR     = 4'd15;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [REG_ID_W-1:0] reg_first;
        logic [REG_ID_W-1:0] reg_second;
        logic [ADDR_W-1:0]   mem_first;
        logic [ADDR_W-1:0]   mem_second;
        logic [SIZE_W-1:0]   size;
        logic                flag;
    } t_in_item;

    typedef struct packed {
        logic tainted;
    } t_out_item;

endpackage

`default_nettype wire

// ===== rtl/tpe_ifs.sv =====
// Valid/ready channel interfaces for the operation and result items.
`timescale 1ns / 1ps
`default_nettype none

interface tpe_in_if import tpe_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface tpe_out_if import tpe_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/tpe_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none

module tpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/taint_propagation_engine.sv =====
// Top level of the taint propagation engine: sequencer, register taint and shadow bitmap.
`timescale 1ns / 1ps
`default_nettype none

// The engine keeps one taint bit per architectural register and a shadow
// bitmap with one taint bit per memory byte, and it handles one operation
// item at a time: queries, set operations and the assignment, ALU and
// expression propagation rules. Every accepted item yields exactly one
// result item carrying the tainted bit. Register ids at or above NUM_REGS
// read as untainted and writes to them are dropped; byte addresses wrap
// modulo 2**ADDR_BITS and a range size above MAX_ACCESS is saturated.
// After reset the shadow bitmap is swept clean, one row of eight bytes per
// cycle, over all 2**(ADDR_BITS-3) rows; no item is accepted during that
// sweep. An item then passes through the states RD_A, RD_B and CAP_B, which
// read both source registers from the single-port register RAM, then M_SRC,
// M_DST and M_MOD for every byte of its memory range, a source read, a
// destination read and a write-back on the single-port shadow RAM, and
// last W_REG, which waits for the output register to be free, updates the
// register and loads the result. The result sits in an output register, so
// a new item is taken while the previous result still waits to be consumed.
module taint_propagation_engine
    import tpe_pkg::*;
#(
    parameter int NUM_REGS   = NUM_REGS_DEF,
    parameter int ADDR_BITS  = ADDR_BITS_DEF,
    parameter int MAX_ACCESS = MAX_ACCESS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tpe_in_if.sink     i_in,
    tpe_out_if.source  o_out
);

    localparam int RA        = $clog2(NUM_REGS);
    localparam int REG_SLOTS = 2 ** RA;
    localparam int ROW_W     = ADDR_BITS - 3;
    localparam int ROWS      = 2 ** ROW_W;
    localparam int LANE_SEL  = $clog2(LANE_W);

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_RD_A  = 4'd2;
    localparam logic [3:0] ST_RD_B  = 4'd3;
    localparam logic [3:0] ST_CAP_B = 4'd4;
    localparam logic [3:0] ST_M_SRC = 4'd5;
    localparam logic [3:0] ST_M_DST = 4'd6;
    localparam logic [3:0] ST_M_MOD = 4'd7;
    localparam logic [3:0] ST_W_REG = 4'd8;

    // Control state.
    logic [3:0]           r_state, n_state;
    logic [ROW_W-1:0]     r_clr, n_clr;
    logic [REG_SLOTS-1:0] r_reg_vld, n_reg_vld;
    logic                 r_out_vld, n_out_vld;

    // Item payload and working bits.
    logic [ACTION_W-1:0]  r_act, n_act;
    logic [REG_ID_W-1:0]  r_r1, n_r1;
    logic [REG_ID_W-1:0]  r_r2, n_r2;
    logic                 r_flag, n_flag;
    logic [ADDR_BITS-1:0] r_src, n_src;
    logic [ADDR_BITS-1:0] r_dst, n_dst;
    logic [SIZE_W-1:0]    r_cnt, n_cnt;
    logic                 r_a, n_a;
    logic                 r_b, n_b;
    logic                 r_acc, n_acc;
    logic                 r_sbit, n_sbit;
    logic                 r_out_tnt, n_out_tnt;

    // RAM ports.
    logic                 reg_we;
    logic [RA-1:0]        reg_addr;
    logic                 reg_wd;
    logic                 reg_rd;
    logic                 sh_we;
    logic [ROW_W-1:0]     sh_addr;
    logic [LANE_W-1:0]    sh_wd;
    logic [LANE_W-1:0]    sh_rd;

    logic                 r1_ok, r2_ok;
    logic [RA-1:0]        r1_idx, r2_idx;
    logic                 mem_op;
    logic                 out_free;
    logic                 in_acc;
    logic [SIZE_W-1:0]    sat_size;
    logic                 dbit;
    logic                 new_bit;
    logic                 do_wr;
    logic                 acc_bit;
    logic                 res;
    logic                 reg_wr_en;
    logic                 reg_wr_val;

    tpe_ram #(
        .WIDTH(1),
        .DEPTH(NUM_REGS)
    ) u_reg_ram (
        .i_clk  (i_clk),
        .i_we   (reg_we),
        .i_addr (reg_addr),
        .i_wdata(reg_wd),
        .o_rdata(reg_rd)
    );

    tpe_ram #(
        .WIDTH(LANE_W),
        .DEPTH(ROWS)
    ) u_shadow_ram (
        .i_clk  (i_clk),
        .i_we   (sh_we),
        .i_addr (sh_addr),
        .i_wdata(sh_wd),
        .o_rdata(sh_rd)
    );

    assign r1_ok    = 32'(r_r1) < NUM_REGS;
    assign r2_ok    = 32'(r_r2) < NUM_REGS;
    assign r1_idx   = RA'(r_r1);
    assign r2_idx   = RA'(r_r2);
    assign out_free = !r_out_vld || o_out.ready;

    assign i_in.ready       = (r_state == ST_IDLE);
    assign in_acc           = i_in.valid && i_in.ready;
    assign o_out.valid      = r_out_vld;
    assign o_out.data.tainted = r_out_tnt;

    assign sat_size = (32'(i_in.data.size) > MAX_ACCESS) ? SIZE_W'(MAX_ACCESS)
                                                         : i_in.data.size;

    // Operations that walk a byte range of the shadow bitmap.
    always_comb begin
        unique case (r_act) inside
            ACT_QMEM, ACT_SETMEM, ACT_ASSIGN_RM, ACT_ASSIGN_MM, ACT_ASSIGN_MI,
            ACT_ASSIGN_MR, ACT_EXPR_RM, ACT_ALU_RM, ACT_ALU_MM, ACT_ALU_MR:
                mem_op = 1'b1;
            default:
                mem_op = 1'b0;
        endcase
    end

    // Per-byte rule: new destination bit, whether it is written, and what
    // the byte adds to the running OR.
    assign dbit = sh_rd[r_dst[LANE_SEL-1:0]];

    always_comb begin
        new_bit = 1'b0;
        do_wr   = 1'b0;
        acc_bit = 1'b0;
        case (r_act)
            ACT_SETMEM: begin
                new_bit = r_flag;
                do_wr   = 1'b1;
            end
            ACT_ASSIGN_MM: begin
                new_bit = r_sbit;
                do_wr   = 1'b1;
                acc_bit = r_sbit;
            end
            ACT_ASSIGN_MI: begin
                do_wr   = 1'b1;
            end
            ACT_ASSIGN_MR: begin
                new_bit = r_b;
                do_wr   = 1'b1;
                acc_bit = r_b;
            end
            ACT_ALU_MM: begin
                new_bit = dbit | r_sbit;
                do_wr   = 1'b1;
                acc_bit = dbit | r_sbit;
            end
            ACT_ALU_MR: begin
                // A tainted source register taints the whole range; otherwise
                // the range is only scanned.
                new_bit = 1'b1;
                do_wr   = r_b;
                acc_bit = dbit;
            end
            default: begin
                acc_bit = r_sbit;
            end
        endcase
    end

    // Result and register update of the finished operation.
    always_comb begin
        res        = 1'b0;
        reg_wr_en  = 1'b0;
        reg_wr_val = 1'b0;
        case (r_act)
            ACT_QREG:      res = r_a;
            ACT_QMEM:      res = r_acc;
            ACT_SETREG: begin
                res        = r1_ok & r_flag;
                reg_wr_en  = 1'b1;
                reg_wr_val = r_flag;
            end
            ACT_SETMEM:    res = r_flag;
            ACT_ASSIGN_RR: begin
                res        = r_b;
                reg_wr_en  = 1'b1;
                reg_wr_val = r_b;
            end
            ACT_ASSIGN_RI: begin
                reg_wr_en  = 1'b1;
            end
            ACT_ASSIGN_RM: begin
                res        = r_acc;
                reg_wr_en  = 1'b1;
                reg_wr_val = r_acc;
            end
            ACT_ASSIGN_MM: res = r_acc;
            ACT_ASSIGN_MI: res = 1'b0;
            ACT_ASSIGN_MR: res = r_acc;
            ACT_EXPR_RR:   res = r_a | r_b;
            ACT_EXPR_RM:   res = r_a | r_acc;
            ACT_ALU_RR: begin
                res        = r_a | r_b;
                reg_wr_en  = r_b;
                reg_wr_val = 1'b1;
            end
            ACT_ALU_RM: begin
                res        = r_a | r_acc;
                reg_wr_en  = r_acc;
                reg_wr_val = 1'b1;
            end
            ACT_ALU_MM:    res = r_acc;
            default:       res = r_b | r_acc;
        endcase
    end

    // Sequencer.
    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_reg_vld = r_reg_vld;
        n_out_vld = r_out_vld && !o_out.ready;
        n_out_tnt = r_out_tnt;
        n_act     = r_act;
        n_r1      = r_r1;
        n_r2      = r_r2;
        n_flag    = r_flag;
        n_src     = r_src;
        n_dst     = r_dst;
        n_cnt     = r_cnt;
        n_a       = r_a;
        n_b       = r_b;
        n_acc     = r_acc;
        n_sbit    = r_sbit;
        reg_we    = 1'b0;
        reg_addr  = r1_idx;
        reg_wd    = reg_wr_val;
        sh_we     = 1'b0;
        sh_addr   = r_src[ADDR_BITS-1:LANE_SEL];
        sh_wd     = sh_rd;

        unique case (r_state)
            ST_CLEAR: begin
                sh_we   = 1'b1;
                sh_addr = r_clr;
                sh_wd   = '0;
                n_clr   = r_clr + 1'b1;
                if (r_clr == ROW_W'(ROWS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    n_act   = i_in.data.action;
                    n_r1    = i_in.data.reg_first;
                    n_r2    = i_in.data.reg_second;
                    n_flag  = i_in.data.flag;
                    n_src   = ADDR_BITS'(i_in.data.mem_second);
                    n_dst   = ADDR_BITS'(i_in.data.mem_first);
                    n_cnt   = (i_in.data.action == ACT_SETMEM) ? SIZE_W'(1) : sat_size;
                    n_acc   = 1'b0;
                    n_state = ST_RD_A;
                end
            end
            ST_RD_A: begin
                reg_addr = r1_idx;
                n_state  = ST_RD_B;
            end
            ST_RD_B: begin
                n_a      = r1_ok & r_reg_vld[r1_idx] & reg_rd;
                reg_addr = r2_idx;
                n_state  = ST_CAP_B;
            end
            ST_CAP_B: begin
                n_b     = r2_ok & r_reg_vld[r2_idx] & reg_rd;
                n_state = (mem_op && (r_cnt != '0)) ? ST_M_SRC : ST_W_REG;
            end
            ST_M_SRC: begin
                sh_addr = r_src[ADDR_BITS-1:LANE_SEL];
                n_state = ST_M_DST;
            end
            ST_M_DST: begin
                n_sbit  = sh_rd[r_src[LANE_SEL-1:0]];
                sh_addr = r_dst[ADDR_BITS-1:LANE_SEL];
                n_state = ST_M_MOD;
            end
            ST_M_MOD: begin
                // The write lands before the next byte's source read, so
                // overlapping ranges see bytes written earlier in the item.
                sh_addr = r_dst[ADDR_BITS-1:LANE_SEL];
                sh_we   = do_wr;
                sh_wd   = sh_rd;
                sh_wd[r_dst[LANE_SEL-1:0]] = new_bit;
                n_acc   = r_acc | acc_bit;
                n_src   = r_src + 1'b1;
                n_dst   = r_dst + 1'b1;
                n_cnt   = r_cnt - 1'b1;
                n_state = (r_cnt == SIZE_W'(1)) ? ST_W_REG : ST_M_SRC;
            end
            ST_W_REG: begin
                if (out_free) begin
                    reg_addr  = r1_idx;
                    reg_we    = reg_wr_en && r1_ok;
                    reg_wd    = reg_wr_val;
                    if (reg_wr_en && r1_ok) begin
                        n_reg_vld[r1_idx] = 1'b1;
                    end
                    n_out_vld = 1'b1;
                    n_out_tnt = res;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr     <= '0;
            r_reg_vld <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_reg_vld <= n_reg_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act     <= n_act;
        r_r1      <= n_r1;
        r_r2      <= n_r2;
        r_flag    <= n_flag;
        r_src     <= n_src;
        r_dst     <= n_dst;
        r_cnt     <= n_cnt;
        r_a       <= n_a;
        r_b       <= n_b;
        r_acc     <= n_acc;
        r_sbit    <= n_sbit;
        r_out_tnt <= n_out_tnt;
    end

endmodule

`default_nettype wire

// ===== rtl/tpe_checker.sv =====
// Port-level checker of the taint propagation engine and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "taint_propagation_engine_defines.svh"

module tpe_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire logic i_out_tainted
);

    logic       in_acc;
    logic       out_acc;
    logic [1:0] r_pend;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // Items accepted but not yet delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + 2'(in_acc) - 2'(out_acc);
        end
    end

    // Only one item is worked on at a time.
    `TPE_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, in_acc, !i_in_ready)
    // A result is never shown without an item behind it.
    `TPE_ASSERT_IMPL(a_no_spurious_out, i_clk, i_rst_n, i_out_valid, r_pend != 2'd0)
    // At most one finished result waits while a new item is taken.
    `TPE_ASSERT_IMPL(a_pend_bound, i_clk, i_rst_n, in_acc, r_pend <= 2'd1)
    // A stalled result holds.
    `TPE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
                     i_out_valid && $stable(i_out_tainted))

endmodule

bind taint_propagation_engine tpe_checker u_tpe_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_tainted(o_out.data.tainted)
);

`default_nettype wire
